// File: hdl/vau_pkg.sv
package vau_pkg;

    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int XW          = 42;
    localparam int ZW          = 44;
    localparam int SQ_STEPS    = 32;
    localparam int SHIFT_STEPS = 6;
    localparam int GUARD       = 8;
    localparam int MW          = 40;

    localparam logic signed [ZW-1:0] PI_Q30      = 44'sd3373259426;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 44'sd6746518852;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 44'sd1686629713;
    localparam logic signed [32:0]   INV_GAIN    = 33'sd652032874;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_SCALE = 4'd2;
    localparam logic [3:0] OP_MAG   = 4'd3;
    localparam logic [3:0] OP_NORM  = 4'd4;
    localparam logic [3:0] OP_ANG   = 4'd5;
    localparam logic [3:0] OP_DIST  = 4'd6;
    localparam logic [3:0] OP_DANG  = 4'd7;
    localparam logic [3:0] OP_ROT   = 4'd8;

    typedef struct packed {
        logic               ov;
        logic signed [31:0] val;
    } sat_t;

    typedef struct packed {
        logic                 vec;
        logic [3:0]           op;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [MW-1:0]        m;
        logic signed [31:0]   rx;
        logic signed [31:0]   ry;
        logic                 ov;
        logic                 zv;
    } cord_t;

    typedef struct packed {
        logic [63:0]        v;
        logic [63:0]        r;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
    } sq_t;

    typedef struct packed {
        logic sx;
        logic sy;
    } div_ctl_t;

    function automatic sat_t sat_fn(input logic signed [79:0] v, input int sw);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        sat_t               res;
        hi = (80'sd1 <<< (sw - 1)) - 80'sd1;
        lo = -hi - 80'sd1;
        res.ov = 1'b0;
        if (v > hi)
        begin
            res.ov  = 1'b1;
            res.val = 32'(hi);
        end
        else if (v < lo)
        begin
            res.ov  = 1'b1;
            res.val = 32'(lo);
        end
        else
        begin
            res.val = 32'(v);
        end
        return res;
    endfunction

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 44'sd843314857;
            1:       a = 44'sd497837829;
            2:       a = 44'sd263043837;
            3:       a = 44'sd133525159;
            4:       a = 44'sd67021687;
            5:       a = 44'sd33543516;
            6:       a = 44'sd16775851;
            7:       a = 44'sd8388437;
            8:       a = 44'sd4194283;
            9:       a = 44'sd2097149;
            10:      a = 44'sd1048576;
            11:      a = 44'sd524288;
            12:      a = 44'sd262144;
            13:      a = 44'sd131072;
            14:      a = 44'sd65536;
            15:      a = 44'sd32768;
            16:      a = 44'sd16384;
            17:      a = 44'sd8192;
            18:      a = 44'sd4096;
            19:      a = 44'sd2048;
            20:      a = 44'sd1024;
            21:      a = 44'sd512;
            22:      a = 44'sd256;
            23:      a = 44'sd128;
            24:      a = 44'sd64;
            25:      a = 44'sd32;
            26:      a = 44'sd16;
            27:      a = 44'sd8;
            28:      a = 44'sd4;
            29:      a = 44'sd2;
            30:      a = 44'sd1;
            default: a = 44'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/vau_front.sv
module vau_front #(
    parameter int DATA_WIDTH = vau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vau_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [3:0]            op_in,
    input  logic signed [31:0]    ax_in,
    input  logic signed [31:0]    ay_in,
    input  logic signed [31:0]    bx_in,
    input  logic signed [31:0]    by_in,
    input  logic signed [31:0]    sf_in,
    input  logic signed [19:0]    ang_in,
    output vau_pkg::cord_t        cord_out,
    output vau_pkg::sq_t          sq_out
);

    localparam int SW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ASH = 30 - FRAC_BITS;
    localparam int XW  = vau_pkg::XW;
    localparam int ZW  = vau_pkg::ZW;
    localparam int MW  = vau_pkg::MW;

    vau_pkg::sat_t sdx, sdy, sax, say;
    logic          is_diff;

    logic [3:0]         s1_op_reg;
    logic signed [31:0] s1_ax_reg, s1_ay_reg, s1_sf_reg;
    logic signed [19:0] s1_ang_reg;
    logic signed [31:0] s1_dx_reg, s1_dy_reg, s1_addx_reg, s1_addy_reg;
    logic               s1_ov_reg;

    always_comb
    begin
        sdx = vau_pkg::sat_fn(80'(ax_in) - 80'(bx_in), SW);
        sdy = vau_pkg::sat_fn(80'(ay_in) - 80'(by_in), SW);
        sax = vau_pkg::sat_fn(80'(ax_in) + 80'(bx_in), SW);
        say = vau_pkg::sat_fn(80'(ay_in) + 80'(by_in), SW);
        is_diff = (op_in == vau_pkg::OP_SUB) || (op_in == vau_pkg::OP_DIST) ||
                  (op_in == vau_pkg::OP_DANG);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= op_in;
            s1_ax_reg   <= ax_in;
            s1_ay_reg   <= ay_in;
            s1_sf_reg   <= sf_in;
            s1_ang_reg  <= ang_in;
            s1_dx_reg   <= is_diff ? sdx.val : ax_in;
            s1_dy_reg   <= is_diff ? sdy.val : ay_in;
            s1_addx_reg <= sax.val;
            s1_addy_reg <= say.val;
            s1_ov_reg   <= (is_diff && (sdx.ov || sdy.ov)) ||
                           ((op_in == vau_pkg::OP_ADD) && (sax.ov || say.ov));
        end
    end

    logic signed [32:0]   a0, b0, a1, b1, adx, ady;
    logic signed [65:0]   p0_next, p1_next;
    logic signed [ZW-1:0] zr, zw_next;
    logic                 zv_next;

    logic [3:0]           s2_op_reg;
    logic signed [65:0]   s2_p0_reg, s2_p1_reg;
    logic signed [ZW-1:0] s2_z_reg;
    logic signed [31:0]   s2_dx_reg, s2_dy_reg, s2_addx_reg, s2_addy_reg;
    logic                 s2_ov_reg, s2_zv_reg;

    always_comb
    begin
        adx = s1_dx_reg[31] ? -33'(s1_dx_reg) : 33'(s1_dx_reg);
        ady = s1_dy_reg[31] ? -33'(s1_dy_reg) : 33'(s1_dy_reg);
        case (s1_op_reg)
            vau_pkg::OP_SCALE:
            begin
                a0 = 33'(s1_ax_reg);
                b0 = 33'(s1_sf_reg);
                a1 = 33'(s1_ay_reg);
                b1 = 33'(s1_sf_reg);
            end
            vau_pkg::OP_ROT:
            begin
                a0 = 33'(s1_ax_reg);
                b0 = vau_pkg::INV_GAIN;
                a1 = 33'(s1_ay_reg);
                b1 = vau_pkg::INV_GAIN;
            end
            vau_pkg::OP_MAG, vau_pkg::OP_DIST, vau_pkg::OP_NORM:
            begin
                a0 = adx;
                b0 = adx;
                a1 = ady;
                b1 = ady;
            end
            default:
            begin
                a0 = '0;
                b0 = '0;
                a1 = '0;
                b1 = '0;
            end
        endcase
        p0_next = a0 * b0;
        p1_next = a1 * b1;
        zr = ZW'(s1_ang_reg) <<< ASH;
        if (zr > vau_pkg::PI_Q30)
            zw_next = zr - vau_pkg::TWO_PI_Q30;
        else if (zr < -vau_pkg::PI_Q30)
            zw_next = zr + vau_pkg::TWO_PI_Q30;
        else
            zw_next = zr;
        zv_next = ((s1_op_reg == vau_pkg::OP_NORM) || (s1_op_reg == vau_pkg::OP_ANG) ||
                   (s1_op_reg == vau_pkg::OP_DANG)) &&
                  (s1_dx_reg == 32'sd0) && (s1_dy_reg == 32'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_p0_reg   <= p0_next;
            s2_p1_reg   <= p1_next;
            s2_z_reg    <= zw_next;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_addx_reg <= s1_addx_reg;
            s2_addy_reg <= s1_addy_reg;
            s2_ov_reg   <= s1_ov_reg;
            s2_zv_reg   <= zv_next;
        end
    end

    vau_pkg::sat_t        scx, scy;
    vau_pkg::cord_t       c3;
    vau_pkg::sq_t         q3;
    logic signed [32:0]   xv, yv, ayv;
    logic signed [XW-1:0] xr, yr;
    logic                 vec;

    always_comb
    begin
        scx = vau_pkg::sat_fn(80'(s2_p0_reg >>> FRAC_BITS), SW);
        scy = vau_pkg::sat_fn(80'(s2_p1_reg >>> FRAC_BITS), SW);
        vec = (s2_op_reg == vau_pkg::OP_ANG) || (s2_op_reg == vau_pkg::OP_DANG);
        c3.vec = vec;
        c3.op  = s2_op_reg;
        c3.ov  = s2_ov_reg;
        c3.zv  = s2_zv_reg;
        c3.m   = '0;
        case (s2_op_reg)
            vau_pkg::OP_ADD:
            begin
                c3.rx = s2_addx_reg;
                c3.ry = s2_addy_reg;
            end
            vau_pkg::OP_SUB:
            begin
                c3.rx = s2_dx_reg;
                c3.ry = s2_dy_reg;
            end
            vau_pkg::OP_SCALE:
            begin
                c3.rx = scx.val;
                c3.ry = scy.val;
                c3.ov = s2_ov_reg || scx.ov || scy.ov;
            end
            default:
            begin
                c3.rx = '0;
                c3.ry = '0;
            end
        endcase
        xv = 33'(s2_dx_reg);
        yv = 33'(s2_dy_reg);
        xr = XW'(s2_p0_reg >>> (30 - vau_pkg::GUARD));
        yr = XW'(s2_p1_reg >>> (30 - vau_pkg::GUARD));
        ayv = '0;
        if (vec)
        begin
            if (xv < 0)
            begin
                if (yv >= 0)
                begin
                    c3.x = XW'(yv);
                    c3.y = -XW'(xv);
                    c3.z = vau_pkg::HALF_PI_Q30;
                end
                else
                begin
                    c3.x = -XW'(yv);
                    c3.y = XW'(xv);
                    c3.z = -vau_pkg::HALF_PI_Q30;
                end
            end
            else
            begin
                c3.x = XW'(xv);
                c3.y = XW'(yv);
                c3.z = '0;
            end
            ayv = c3.y[XW-1] ? -33'(c3.y) : 33'(c3.y);
            c3.m = (33'(c3.x) > ayv) ? MW'(c3.x) : MW'(ayv);
        end
        else
        begin
            if (s2_z_reg > vau_pkg::HALF_PI_Q30)
            begin
                c3.x = -yr;
                c3.y = xr;
                c3.z = s2_z_reg - vau_pkg::HALF_PI_Q30;
            end
            else if (s2_z_reg < -vau_pkg::HALF_PI_Q30)
            begin
                c3.x = yr;
                c3.y = -xr;
                c3.z = s2_z_reg + vau_pkg::HALF_PI_Q30;
            end
            else
            begin
                c3.x = xr;
                c3.y = yr;
                c3.z = s2_z_reg;
            end
        end
        q3.v  = s2_p0_reg[63:0] + s2_p1_reg[63:0];
        q3.r  = '0;
        q3.ax = s2_dx_reg;
        q3.ay = s2_dy_reg;
    end

    vau_pkg::cord_t s3_cord_reg;
    vau_pkg::sq_t   s3_sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_cord_reg <= c3;
            s3_sq_reg   <= q3;
        end
    end

    vau_pkg::cord_t sh_in [vau_pkg::SHIFT_STEPS];
    vau_pkg::cord_t sh_nx [vau_pkg::SHIFT_STEPS];
    vau_pkg::cord_t sh_reg [vau_pkg::SHIFT_STEPS];

    for (genvar j = 0; j < vau_pkg::SHIFT_STEPS; j++)
    begin : g_shift
        localparam int AMT = 32 >> j;
        if (j == 0)
        begin : g_first
            assign sh_in[j] = s3_cord_reg;
        end
        else
        begin : g_next
            assign sh_in[j] = sh_reg[j-1];
        end
        always_comb
        begin
            sh_nx[j] = sh_in[j];
            if (sh_in[j].vec && ((sh_in[j].m >> (39 - AMT)) == '0))
            begin
                sh_nx[j].x = sh_in[j].x <<< AMT;
                sh_nx[j].y = sh_in[j].y <<< AMT;
                sh_nx[j].m = sh_in[j].m << AMT;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sh_reg[j] <= sh_nx[j];
        end
    end

    assign cord_out = sh_reg[vau_pkg::SHIFT_STEPS-1];
    assign sq_out   = s3_sq_reg;

endmodule

// File: hdl/vau_cordic_cell.sv
module vau_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           en,
    input  vau_pkg::cord_t d_in,
    output vau_pkg::cord_t d_out
);

    localparam logic signed [vau_pkg::ZW-1:0] ANG = vau_pkg::atan_q30(STEP);

    logic signed [vau_pkg::XW-1:0] xs, ys;
    logic                          neg;
    vau_pkg::cord_t                d_next;
    vau_pkg::cord_t                d_reg;

    always_comb
    begin
        xs = d_in.x >>> STEP;
        ys = d_in.y >>> STEP;
        neg = d_in.vec ? (d_in.y > 0) : (d_in.z < 0);
        d_next = d_in;
        if (neg)
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + ANG;
        end
        else
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

// File: hdl/vau_sqrt_cell.sv
module vau_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic         clk,
    input  logic         en,
    input  vau_pkg::sq_t d_in,
    output vau_pkg::sq_t d_out
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0]  t;
    vau_pkg::sq_t d_next;
    vau_pkg::sq_t d_reg;

    always_comb
    begin
        t = d_in.r + BIT;
        d_next = d_in;
        if (d_in.v >= t)
        begin
            d_next.v = d_in.v - t;
            d_next.r = (d_in.r >> 1) + BIT;
        end
        else
        begin
            d_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

// File: hdl/vau_div_cell.sv
module vau_div_cell #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF,
    parameter int SHIFT     = 0
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [FRAC_BITS+32:0] remx_in,
    input  logic [FRAC_BITS+32:0] remy_in,
    input  logic [FRAC_BITS:0]    qx_in,
    input  logic [FRAC_BITS:0]    qy_in,
    input  logic [31:0]           d_in,
    input  vau_pkg::div_ctl_t     ctl_in,
    output logic [FRAC_BITS+32:0] remx_out,
    output logic [FRAC_BITS+32:0] remy_out,
    output logic [FRAC_BITS:0]    qx_out,
    output logic [FRAC_BITS:0]    qy_out,
    output logic [31:0]           d_out,
    output vau_pkg::div_ctl_t     ctl_out
);

    localparam int RW = FRAC_BITS + 33;

    logic [RW-1:0]          dsh;
    logic [RW-1:0]          remx_next, remy_next;
    logic [FRAC_BITS:0]     qx_next, qy_next;
    logic [RW-1:0]          remx_reg, remy_reg;
    logic [FRAC_BITS:0]     qx_reg, qy_reg;
    logic [31:0]            d_reg;
    vau_pkg::div_ctl_t      ctl_reg;

    always_comb
    begin
        dsh = RW'(d_in) << SHIFT;
        remx_next = remx_in;
        remy_next = remy_in;
        qx_next = qx_in;
        qy_next = qy_in;
        if (remx_in >= dsh)
        begin
            remx_next = remx_in - dsh;
            qx_next[SHIFT] = 1'b1;
        end
        if (remy_in >= dsh)
        begin
            remy_next = remy_in - dsh;
            qy_next[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            d_reg    <= d_in;
            ctl_reg  <= ctl_in;
        end
    end

    assign remx_out = remx_reg;
    assign remy_out = remy_reg;
    assign qx_out   = qx_reg;
    assign qy_out   = qy_reg;
    assign d_out    = d_reg;
    assign ctl_out  = ctl_reg;

endmodule

// File: hdl/vector2d_arith_unit_top.sv
// Stateless 2D vector unit on signed fixed-point values that takes one item per clock when the
// output is free and returns one result item for each, in order, through the output register.
// After the front stages the items pass the 32 cells of the magnitude square root followed by
// the FRAC_BITS + 1 cells of the normalize divider; the CORDIC chain of CORDIC_STAGES cells runs
// beside them and is delayed to match. When the output item is not taken the whole chain holds,
// so a new item is accepted in every cycle the output is free.
module vector2d_arith_unit_top #(
    parameter int DATA_WIDTH    = vau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = vau_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = vau_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [183:0] s_tdata,  // ax, ay, bx, by_comp, scale_factor, rotate_angle, zero pad
    input  logic [3:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // rx, ry, scalar_out
    output logic [1:0]   m_tuser   // overflow, zero_vector
);

    localparam int SW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int QB  = FRAC_BITS + 1;
    localparam int RW  = FRAC_BITS + 33;
    localparam int LAT = 3 + vau_pkg::SQ_STEPS + QB;
    localparam int DLY = vau_pkg::SQ_STEPS + QB - vau_pkg::SHIFT_STEPS - CORDIC_STAGES;
    localparam int ZW  = vau_pkg::ZW;

    logic en;
    logic m_tvalid_reg;
    logic [LAT-1:0] vld_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    vau_pkg::cord_t cord_w [CORDIC_STAGES+1];
    vau_pkg::sq_t   sq_w [vau_pkg::SQ_STEPS+1];

    vau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .en       (en),
        .op_in    (s_tuser),
        .ax_in    (s_tdata[31:0]),
        .ay_in    (s_tdata[63:32]),
        .bx_in    (s_tdata[95:64]),
        .by_in    (s_tdata[127:96]),
        .sf_in    (s_tdata[159:128]),
        .ang_in   (s_tdata[179:160]),
        .cord_out (cord_w[0]),
        .sq_out   (sq_w[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        vau_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (cord_w[i]),
            .d_out (cord_w[i+1])
        );
    end

    vau_pkg::cord_t dly_reg [DLY];

    for (genvar g = 0; g < DLY; g++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (g == 0)
                    dly_reg[g] <= cord_w[CORDIC_STAGES];
                else
                    dly_reg[g] <= dly_reg[(g == 0) ? 0 : g - 1];
            end
        end
    end

    for (genvar i = 0; i < vau_pkg::SQ_STEPS; i++)
    begin : g_sqrt
        vau_sqrt_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (sq_w[i]),
            .d_out (sq_w[i+1])
        );
    end

    logic [RW-1:0]     remx_w [QB+1];
    logic [RW-1:0]     remy_w [QB+1];
    logic [QB-1:0]     qx_w [QB+1];
    logic [QB-1:0]     qy_w [QB+1];
    logic [31:0]       d_w [QB+1];
    vau_pkg::div_ctl_t ctl_w [QB+1];
    logic signed [31:0] sax, say;
    logic [31:0]        magx, magy;

    always_comb
    begin
        sax = sq_w[vau_pkg::SQ_STEPS].ax;
        say = sq_w[vau_pkg::SQ_STEPS].ay;
        magx = sax[31] ? (~sax + 32'd1) : sax;
        magy = say[31] ? (~say + 32'd1) : say;
        remx_w[0] = RW'(magx) << FRAC_BITS;
        remy_w[0] = RW'(magy) << FRAC_BITS;
        qx_w[0] = '0;
        qy_w[0] = '0;
        d_w[0] = sq_w[vau_pkg::SQ_STEPS].r[31:0];
        ctl_w[0].sx = sax[31];
        ctl_w[0].sy = say[31];
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        vau_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (QB - 1 - k)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .remx_in  (remx_w[k]),
            .remy_in  (remy_w[k]),
            .qx_in    (qx_w[k]),
            .qy_in    (qy_w[k]),
            .d_in     (d_w[k]),
            .ctl_in   (ctl_w[k]),
            .remx_out (remx_w[k+1]),
            .remy_out (remy_w[k+1]),
            .qx_out   (qx_w[k+1]),
            .qy_out   (qy_w[k+1]),
            .d_out    (d_w[k+1]),
            .ctl_out  (ctl_w[k+1])
        );
    end

    vau_pkg::cord_t     fin;
    vau_pkg::sat_t      s0, s1;
    logic signed [79:0] qsx, qsy;
    logic signed [31:0] rx_next, ry_next, sc_next;
    logic               ov_next, zv_next;
    logic signed [31:0] rx_reg, ry_reg, sc_reg;
    logic               ov_reg, zv_reg;

    always_comb
    begin
        fin = dly_reg[DLY-1];
        qsx = ctl_w[QB].sx ? -80'(qx_w[QB]) : 80'(qx_w[QB]);
        qsy = ctl_w[QB].sy ? -80'(qy_w[QB]) : 80'(qy_w[QB]);
        rx_next = '0;
        ry_next = '0;
        sc_next = '0;
        ov_next = fin.ov;
        zv_next = fin.zv;
        s0 = '0;
        s1 = '0;
        case (fin.op)
            vau_pkg::OP_ADD, vau_pkg::OP_SUB, vau_pkg::OP_SCALE:
            begin
                rx_next = fin.rx;
                ry_next = fin.ry;
            end
            vau_pkg::OP_MAG, vau_pkg::OP_DIST:
            begin
                s0 = vau_pkg::sat_fn(80'(d_w[QB]), SW);
                sc_next = s0.val;
                ov_next = fin.ov || s0.ov;
            end
            vau_pkg::OP_NORM:
            begin
                if (!fin.zv)
                begin
                    s0 = vau_pkg::sat_fn(qsx, SW);
                    s1 = vau_pkg::sat_fn(qsy, SW);
                    rx_next = s0.val;
                    ry_next = s1.val;
                end
            end
            vau_pkg::OP_ANG, vau_pkg::OP_DANG:
            begin
                if (!fin.zv)
                    sc_next = 32'((fin.z + (ZW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
            end
            vau_pkg::OP_ROT:
            begin
                s0 = vau_pkg::sat_fn((80'(fin.x) + 80'sd128) >>> vau_pkg::GUARD, SW);
                s1 = vau_pkg::sat_fn((80'(fin.y) + 80'sd128) >>> vau_pkg::GUARD, SW);
                rx_next = s0.val;
                ry_next = s1.val;
                ov_next = fin.ov || s0.ov || s1.ov;
            end
            default:
            begin
                ov_next = 1'b0;
                zv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            sc_reg <= sc_next;
            ov_reg <= ov_next;
            zv_reg <= zv_next;
        end
    end

    assign m_tdata = {sc_reg, ry_reg, rx_reg};
    assign m_tuser = {zv_reg, ov_reg};

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;
    localparam int N_RANDOM = 600;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [3:0] op;
        longint ax, ay, bx, by, sf, ang;
    } vec_item_t;

    typedef struct {
        longint rx, ry, sc;
        bit ov, zv;
    } vec_res_t;

    typedef struct {
        vec_item_t it;
        bit typed;
        vec_res_t res;
    } tab_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [183:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0] m_tuser;

    bit cur_typed = 1'b0;
    vec_res_t cur_res;
    vec_res_t result_q[$];
    tab_row_t dir_tab[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int idle_cnt = 0;
    bit hold_done = 1'b0;

    vector2d_arith_unit_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    function automatic longint sat32(longint v, inout bit ov);
        if (v > S_MAX)
        begin
            ov = 1'b1;
            return S_MAX;
        end
        if (v < S_MIN)
        begin
            ov = 1'b1;
            return S_MIN;
        end
        return v;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vec_len(longint x, longint y);
        longint unsigned ux;
        longint unsigned uy;
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        return root_floor(ux * ux + uy * uy);
    endfunction

    function automatic longint atan_step(int i);
        longint tab[18];
        tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
                65536, 32768, 16384, 8192};
        return tab[i];
    endfunction

    function automatic longint heading(longint x, longint y);
        longint z, t, m, nx, ny;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 64'sd1686629713;
            end
            else
            begin
                x = -y;
                y = t;
                z = -64'sd1686629713;
            end
        end
        m = (x < 0) ? -x : x;
        t = (y < 0) ? -y : y;
        if (t > m)
            m = t;
        while (m < (64'sd1 << 38))
        begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 18; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + atan_step(i);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - atan_step(i);
            end
            x = nx;
            y = ny;
        end
        return (z + (64'sd1 << 13)) >>> 14;
    endfunction

    function automatic void turn(longint x, longint y, longint ang,
                                 output longint ox, output longint oy, inout bit ov);
        longint z, t, nx, ny;
        z = ang * (64'sd1 << 14);
        if (z > 64'sd3373259426)
            z = z - 64'sd6746518852;
        else if (z < -64'sd3373259426)
            z = z + 64'sd6746518852;
        x = (x * 64'sd652032874) >>> 22;
        y = (y * 64'sd652032874) >>> 22;
        if (z > 64'sd1686629713)
        begin
            t = x;
            x = -y;
            y = t;
            z = z - 64'sd1686629713;
        end
        else if (z < -64'sd1686629713)
        begin
            t = x;
            x = y;
            y = -t;
            z = z + 64'sd1686629713;
        end
        for (int i = 0; i < 18; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - atan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + atan_step(i);
            end
            x = nx;
            y = ny;
        end
        ox = sat32((x + 64'sd128) >>> 8, ov);
        oy = sat32((y + 64'sd128) >>> 8, ov);
    endfunction

    function automatic vec_res_t vector_result(vec_item_t it);
        vec_res_t r;
        longint dx, dy, m;
        bit scratch;
        r = '{0, 0, 0, 1'b0, 1'b0};
        scratch = 1'b0;
        if (it.op == vau_pkg::OP_SUB || it.op == vau_pkg::OP_DIST ||
            it.op == vau_pkg::OP_DANG)
        begin
            dx = sat32(it.ax - it.bx, r.ov);
            dy = sat32(it.ay - it.by, r.ov);
        end
        else
        begin
            dx = it.ax;
            dy = it.ay;
        end
        case (it.op)
            vau_pkg::OP_ADD:
            begin
                r.rx = sat32(it.ax + it.bx, r.ov);
                r.ry = sat32(it.ay + it.by, r.ov);
            end
            vau_pkg::OP_SUB:
            begin
                r.rx = dx;
                r.ry = dy;
            end
            vau_pkg::OP_SCALE:
            begin
                r.rx = sat32((it.ax * it.sf) >>> 16, r.ov);
                r.ry = sat32((it.ay * it.sf) >>> 16, r.ov);
            end
            vau_pkg::OP_MAG, vau_pkg::OP_DIST:
                r.sc = sat32(vec_len(dx, dy), r.ov);
            vau_pkg::OP_NORM:
            begin
                m = vec_len(it.ax, it.ay);
                if (m == 0)
                    r.zv = 1'b1;
                else
                begin
                    r.rx = sat32((it.ax * 65536) / m, scratch);
                    r.ry = sat32((it.ay * 65536) / m, scratch);
                end
            end
            vau_pkg::OP_ANG, vau_pkg::OP_DANG:
            begin
                if (dx == 0 && dy == 0)
                    r.zv = 1'b1;
                else
                    r.sc = heading(dx, dy);
            end
            vau_pkg::OP_ROT:
                turn(it.ax, it.ay, it.ang, r.rx, r.ry, r.ov);
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic longint pick_value();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return longint'($signed($urandom_range(0, 1048575))) - 524288;
            3: return longint'($signed(32'($urandom))) >>> $urandom_range(4, 12);
            default: return longint'($signed(32'($urandom)));
        endcase
    endfunction

    task automatic add_row(logic [3:0] op, longint ax, longint ay, longint bx, longint by,
                           longint sf, longint ang, bit typed, vec_res_t res);
        tab_row_t row;
        row.it = '{op, ax, ay, bx, by, sf, ang};
        row.typed = typed;
        row.res = res;
        dir_tab.push_back(row);
    endtask

    task automatic offer(vec_item_t it, bit typed, vec_res_t res);
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {4'b0, it.ang[19:0], it.sf[31:0], it.by[31:0], it.bx[31:0],
                    it.ay[31:0], it.ax[31:0]};
        cur_typed <= typed;
        cur_res <= res;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            vec_item_t it;
            it.op = s_tuser;
            it.ax = longint'($signed(s_tdata[31:0]));
            it.ay = longint'($signed(s_tdata[63:32]));
            it.bx = longint'($signed(s_tdata[95:64]));
            it.by = longint'($signed(s_tdata[127:96]));
            it.sf = longint'($signed(s_tdata[159:128]));
            it.ang = longint'($signed(s_tdata[179:160]));
            result_q.push_back(cur_typed ? cur_res : vector_result(it));
        end
        if (m_tvalid && m_tready)
        begin
            vec_res_t e;
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected item %h %b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = result_q.pop_front();
                checked++;
                if (m_tdata[31:0] !== 32'(e.rx) || m_tdata[63:32] !== 32'(e.ry)
                    || m_tdata[95:64] !== 32'(e.sc) || m_tuser[0] !== e.ov
                    || m_tuser[1] !== e.zv)
                begin
                    $display("%0t: mismatch expected rx=%h ry=%h sc=%h ov=%b zv=%b", $time,
                             32'(e.rx), 32'(e.ry), 32'(e.sc), e.ov, e.zv);
                    $display("%0t:          actual   rx=%h ry=%h sc=%h ov=%b zv=%b", $time,
                             m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0],
                             m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= 150)
            begin
                hold_done = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (((sent / 100) % 3) == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("%0t: no progress, %0d items outstanding", $time, result_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        vec_res_t none;
        vec_res_t r;
        vec_item_t it;
        int burst;
        none = '{0, 0, 0, 1'b0, 1'b0};
        add_row(vau_pkg::OP_ADD, S_MAX, 0, S_MAX, 0, 0, 0, 1, '{S_MAX, 0, 0, 1'b1, 1'b0});
        add_row(vau_pkg::OP_SUB, S_MIN, S_MIN, S_MAX, 1, 0, 0, 1,
                '{S_MIN, S_MIN, 0, 1'b1, 1'b0});
        add_row(vau_pkg::OP_SCALE, 5, -7, 0, 0, 65536, 0, 1, '{5, -7, 0, 1'b0, 1'b0});
        add_row(vau_pkg::OP_SCALE, S_MAX, S_MIN, 0, 0, S_MAX, 0, 0, none);
        add_row(vau_pkg::OP_SCALE, S_MIN, 12345, 0, 0, S_MIN, 0, 0, none);
        add_row(vau_pkg::OP_MAG, 3 << 16, 4 << 16, 0, 0, 0, 0, 1,
                '{0, 0, 5 << 16, 1'b0, 1'b0});
        add_row(vau_pkg::OP_MAG, S_MIN, S_MIN, 0, 0, 0, 0, 1, '{0, 0, S_MAX, 1'b1, 1'b0});
        add_row(vau_pkg::OP_NORM, 0, 0, 7, 7, 0, 0, 1, '{0, 0, 0, 1'b0, 1'b1});
        add_row(vau_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 1, '{65536, 0, 0, 1'b0, 1'b0});
        add_row(vau_pkg::OP_NORM, S_MIN, S_MIN, 0, 0, 0, 0, 0, none);
        add_row(vau_pkg::OP_ANG, 0, 0, 3, 3, 0, 0, 1, '{0, 0, 0, 1'b0, 1'b1});
        add_row(vau_pkg::OP_ANG, -1, 0, 0, 0, 0, 0, 0, none);
        add_row(vau_pkg::OP_ANG, 0, S_MIN, 0, 0, 0, 0, 0, none);
        add_row(vau_pkg::OP_ANG, S_MAX, S_MAX, 0, 0, 0, 0, 0, none);
        add_row(vau_pkg::OP_DIST, S_MAX, S_MAX, S_MIN, S_MIN, 0, 0, 0, none);
        add_row(vau_pkg::OP_DANG, 99, -5, 99, -5, 0, 0, 1, '{0, 0, 0, 1'b0, 1'b1});
        add_row(vau_pkg::OP_DANG, S_MIN, 1, S_MAX, 0, 0, 0, 0, none);
        add_row(vau_pkg::OP_ROT, 1 << 16, 0, 0, 0, 0, 0, 0, none);
        add_row(vau_pkg::OP_ROT, 1 << 16, 1 << 16, 0, 0, 0, 524287, 0, none);
        add_row(vau_pkg::OP_ROT, 1 << 16, -(1 << 16), 0, 0, 0, -524288, 0, none);
        add_row(vau_pkg::OP_ROT, 1 << 16, 0, 0, 0, 0, 102944, 0, none);
        add_row(vau_pkg::OP_ROT, S_MAX, S_MAX, 0, 0, 0, 30000, 0, none);
        add_row(4'd9, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 524287, 1, none);
        add_row(4'd15, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, -524288, 1, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            burst--;
            if (n == 300)
            begin
                s_tvalid <= 1'b0;
                while (checked < sent)
                    @(posedge clk);
                @(posedge clk);
            end
            it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
            it.ax = pick_value();
            it.ay = pick_value();
            it.bx = ($urandom_range(0, 3) == 0) ? it.ax : pick_value();
            it.by = ($urandom_range(0, 3) == 0) ? it.ay : pick_value();
            it.sf = pick_value();
            it.ang = longint'($signed(20'($urandom)));
            offer(it, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (checked < sent)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Sent %0d items over all nine operations and unknown codes, %0d results checked.",
                 sent, checked);
        $display("Included saturation extremes, zero vectors and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/vau_pkg.sv
hdl/vau_front.sv
hdl/vau_cordic_cell.sv
hdl/vau_sqrt_cell.sv
hdl/vau_div_cell.sv
hdl/vector2d_arith_unit_top.sv
bench/tb.sv
